// ----- rtl/lbpd_pkg.sv -----
package lbpd_pkg;

  localparam int MAX_PIXELS_DEF = 1024;
  localparam int MAX_COLORS_DEF = 5;
  localparam int PALETTE_REGS   = 5;

  localparam int IDX_W      = 10;
  localparam int CH_W       = 8;
  localparam int LEVEL_W    = 17;
  localparam int STEP_W     = 17;
  localparam int PIXCNT_W   = 11;
  localparam int COLCNT_W   = 3;
  localparam int COLOR_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int ALU_W      = LEVEL_W + 1;
  localparam int CNT_W      = $clog2(IDX_W);

  localparam logic [LEVEL_W-1:0] FULL_SCALE  = LEVEL_W'(65536);
  localparam logic [LEVEL_W-1:0] FLOOR_LEVEL = LEVEL_W'((65536 * 25) / 100);
  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(655);

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_LOOP  = 2'd1,
    ACT_END   = 2'd2,
    ACT_OFF   = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAL0        = 3'd0,
    REG_PAL1        = 3'd1,
    REG_PAL2        = 3'd2,
    REG_PAL3        = 3'd3,
    REG_PAL4        = 3'd4,
    REG_COLOR_COUNT = 3'd5,
    REG_PIXEL_COUNT = 3'd6,
    REG_STEP        = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [LEVEL_W-1:0] a;
    logic [LEVEL_W-1:0] b;
  } alu_req_t;

endpackage

// ----- rtl/lbpd_ifs.sv -----
interface lbpd_in_if import lbpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [IDX_W-1:0] pixel_index;

  modport source (output valid, output action, output pixel_index, input ready);
  modport sink   (input valid, input action, input pixel_index, output ready);
endinterface

interface lbpd_out_if import lbpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] out_index;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;
  logic             clear_all;
  logic             frame_last;

  modport source (output valid, output out_index, output red, output green, output blue,
                  output clear_all, output frame_last, input ready);
  modport sink   (input valid, input out_index, input red, input green, input blue,
                  input clear_all, input frame_last, output ready);
endinterface

interface lbpd_cfg_if import lbpd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/led_breathing_palette_dimmer.sv -----
// Breathing palette dimmer for an LED strip. Each input transfer carries one pixel slot and
// an action (begin, loop, end, off) and yields exactly one output transfer. Begin and end give
// a black pixel and reset the brightness level to zero, rising after begin and falling after
// end. A loop pixel gives palette color (pixel_index mod color_count), each channel scaled by
// the level and truncated; on the last pixel of the frame the level then moves one step along
// a triangle between a 25 percent floor and full scale. Off gives a clear-strip marker with
// index zero. A small sequencer drives one shared add/subtract/multiply unit: the modulo is a
// restoring division over the ten index bits, then the three channels go through the multiplier
// one after another, then the level step. The result sits in an output register, so an item is
// taken while the previous result waits; the sequencer only stalls in its final state if that
// register is still full. Configuration writes are taken in any cycle and should only be issued
// while the block is idle.
module led_breathing_palette_dimmer import lbpd_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int MAX_COLORS = MAX_COLORS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lbpd_in_if.sink    in_ch,
  lbpd_out_if.source out_ch,
  lbpd_cfg_if.sink   cfg_ch
);

  localparam int MAXC_W = $clog2(MAX_COLORS + 1) + COLCNT_W;
  localparam logic [MAXC_W-1:0]  MAXC = MAXC_W'(MAX_COLORS);
  localparam logic [LEVEL_W-1:0] MAXP = LEVEL_W'(MAX_PIXELS);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MOD    = 7'b0000010,
    ST_MUL_R  = 7'b0000100,
    ST_MUL_G  = 7'b0001000,
    ST_MUL_B  = 7'b0010000,
    ST_LEVEL  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  // Configuration registers.
  logic [COLOR_W-1:0]  pal_r [PALETTE_REGS];
  logic [COLCNT_W-1:0] color_count_r;
  logic [PIXCNT_W-1:0] pixel_count_r;
  logic [STEP_W-1:0]   step_r;

  // Breathing state.
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               rising_r, rising_nxt;

  // Sequencer and working registers.
  state_t              state_r, state_nxt;
  action_t             act_r, act_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                last_r, last_nxt;
  logic [COLCNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CH_W-1:0]     red_r, red_nxt;
  logic [CH_W-1:0]     green_r, green_nxt;
  logic [CH_W-1:0]     blue_r, blue_nxt;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] o_idx_r, o_idx_nxt;
  logic [CH_W-1:0]  o_red_r, o_red_nxt;
  logic [CH_W-1:0]  o_green_r, o_green_nxt;
  logic [CH_W-1:0]  o_blue_r, o_blue_nxt;
  logic             o_clear_r, o_clear_nxt;
  logic             o_last_r, o_last_nxt;

  alu_req_t           alu_req;
  logic [ALU_W-1:0]   alu_res;
  logic [MAXC_W-1:0]  ncol_wide;
  logic [COLCNT_W-1:0] ncol;
  logic [LEVEL_W-1:0] npix;
  logic [LEVEL_W-1:0] step_eff;
  logic [COLOR_W-1:0] slot_color;
  logic [COLCNT_W:0]  rem_shift;
  logic               in_xfer;

  lbpd_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // Out-of-range register values are clamped to the usable range.
  always_comb begin
    if (color_count_r == '0) begin
      ncol_wide = MAXC_W'(1);
    end else if (MAXC_W'(color_count_r) > MAXC) begin
      ncol_wide = MAXC;
    end else begin
      ncol_wide = MAXC_W'(color_count_r);
    end
    ncol = ncol_wide[COLCNT_W-1:0];

    if (pixel_count_r == '0) begin
      npix = LEVEL_W'(1);
    end else if (LEVEL_W'(pixel_count_r) > MAXP) begin
      npix = MAXP;
    end else begin
      npix = LEVEL_W'(pixel_count_r);
    end

    step_eff = (step_r > FULL_SCALE) ? FULL_SCALE : step_r;
  end

  // A slot past the five palette registers reads as black.
  assign slot_color = (rem_r < COLCNT_W'(PALETTE_REGS)) ? pal_r[rem_r] : '0;
  assign rem_shift  = {rem_r, idx_r[cnt_r]};

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_index  = o_idx_r;
  assign out_ch.red        = o_red_r;
  assign out_ch.green      = o_green_r;
  assign out_ch.blue       = o_blue_r;
  assign out_ch.clear_all  = o_clear_r;
  assign out_ch.frame_last = o_last_r;

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    level_nxt     = level_r;
    rising_nxt    = rising_r;
    out_valid_nxt = out_valid_r;
    o_idx_nxt     = o_idx_r;
    o_red_nxt     = o_red_r;
    o_green_nxt   = o_green_r;
    o_blue_nxt    = o_blue_r;
    o_clear_nxt   = o_clear_r;
    o_last_nxt    = o_last_r;
    alu_req.op    = ALU_SUB;
    alu_req.a     = LEVEL_W'(rem_shift);
    alu_req.b     = LEVEL_W'(ncol);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          act_nxt  = action_t'(in_ch.action);
          idx_nxt  = in_ch.pixel_index;
          last_nxt = (LEVEL_W'(in_ch.pixel_index) == npix - LEVEL_W'(1));
          rem_nxt  = '0;
          cnt_nxt  = CNT_W'(IDX_W - 1);
          case (action_t'(in_ch.action))
            ACT_BEGIN: begin
              level_nxt  = '0;
              rising_nxt = 1'b1;
              state_nxt  = ST_FINISH;
            end
            ACT_END: begin
              level_nxt  = '0;
              rising_nxt = 1'b0;
              state_nxt  = ST_FINISH;
            end
            ACT_LOOP: state_nxt = ST_MOD;
            default:  state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_MOD: begin
        // One restoring division step per cycle, most significant index bit first.
        if (!alu_res[ALU_W-1]) begin
          rem_nxt = alu_res[COLCNT_W-1:0];
        end else begin
          rem_nxt = rem_shift[COLCNT_W-1:0];
        end
        if (cnt_r == '0) begin
          state_nxt = ST_MUL_R;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_MUL_R: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = LEVEL_W'(slot_color[23:16]);
        alu_req.b  = level_r;
        red_nxt    = alu_res[CH_W-1:0];
        state_nxt  = ST_MUL_G;
      end
      ST_MUL_G: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = LEVEL_W'(slot_color[15:8]);
        alu_req.b  = level_r;
        green_nxt  = alu_res[CH_W-1:0];
        state_nxt  = ST_MUL_B;
      end
      ST_MUL_B: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = LEVEL_W'(slot_color[7:0]);
        alu_req.b  = level_r;
        blue_nxt   = alu_res[CH_W-1:0];
        state_nxt  = last_r ? ST_LEVEL : ST_FINISH;
      end
      ST_LEVEL: begin
        alu_req.a = level_r;
        alu_req.b = step_eff;
        if (rising_r) begin
          alu_req.op = ALU_ADD;
          if (alu_res >= ALU_W'(FULL_SCALE)) begin
            level_nxt  = FULL_SCALE;
            rising_nxt = 1'b0;
          end else begin
            level_nxt = alu_res[LEVEL_W-1:0];
          end
        end else begin
          // level <= floor + step is the same as a borrow or level - step <= floor.
          alu_req.op = ALU_SUB;
          if (alu_res[ALU_W-1] || (alu_res[LEVEL_W-1:0] <= FLOOR_LEVEL)) begin
            level_nxt  = FLOOR_LEVEL;
            rising_nxt = 1'b1;
          end else begin
            level_nxt = alu_res[LEVEL_W-1:0];
          end
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_idx_nxt     = idx_r;
          o_last_nxt    = last_r;
          o_clear_nxt   = 1'b0;
          o_red_nxt     = '0;
          o_green_nxt   = '0;
          o_blue_nxt    = '0;
          case (act_r)
            ACT_LOOP: begin
              o_red_nxt   = red_r;
              o_green_nxt = green_r;
              o_blue_nxt  = blue_r;
            end
            ACT_OFF: begin
              o_idx_nxt   = '0;
              o_last_nxt  = 1'b0;
              o_clear_nxt = 1'b1;
            end
            default: begin
            end
          endcase
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      level_r     <= FULL_SCALE;
      rising_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      level_r     <= level_nxt;
      rising_r    <= rising_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    idx_r     <= idx_nxt;
    last_r    <= last_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    red_r     <= red_nxt;
    green_r   <= green_nxt;
    blue_r    <= blue_nxt;
    o_idx_r   <= o_idx_nxt;
    o_red_r   <= o_red_nxt;
    o_green_r <= o_green_nxt;
    o_blue_r  <= o_blue_nxt;
    o_clear_r <= o_clear_nxt;
    o_last_r  <= o_last_nxt;
  end

  // Configuration writes; every index of the port maps to a register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PALETTE_REGS; i++) begin
        pal_r[i] <= '0;
      end
      color_count_r <= COLCNT_W'(1);
      pixel_count_r <= PIXCNT_W'(1024);
      step_r        <= STEP_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_PAL0:        pal_r[0]      <= cfg_ch.data[COLOR_W-1:0];
        REG_PAL1:        pal_r[1]      <= cfg_ch.data[COLOR_W-1:0];
        REG_PAL2:        pal_r[2]      <= cfg_ch.data[COLOR_W-1:0];
        REG_PAL3:        pal_r[3]      <= cfg_ch.data[COLOR_W-1:0];
        REG_PAL4:        pal_r[4]      <= cfg_ch.data[COLOR_W-1:0];
        REG_COLOR_COUNT: color_count_r <= cfg_ch.data[COLCNT_W-1:0];
        REG_PIXEL_COUNT: pixel_count_r <= cfg_ch.data[PIXCNT_W-1:0];
        REG_STEP:        step_r        <= cfg_ch.data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The level never exceeds full scale.
  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= FULL_SCALE)
    else $error("level above full scale");

  // While falling, the level is either zero after end or at or above the floor.
  a_level_band: assert property (@(posedge clk) disable iff (!rst_n)
    !rising_r |-> ((level_r == '0) || (level_r >= FLOOR_LEVEL)))
    else $error("falling level between zero and the floor");

  // After an input transfer the sequencer is busy in the next cycle.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("input taken twice in a row");

  // A new result only appears out of the final sequencer state.
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside the final state");

endmodule

// ----- rtl/lbpd_alu.sv -----
module lbpd_alu import lbpd_pkg::*; (
  input  alu_req_t           req,
  output logic [ALU_W-1:0]   res
);

  localparam int PROD_W = CH_W + LEVEL_W;

  // Channel times level; product bits 23 down to 16 are the scaled channel.
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(req.a[CH_W-1:0]) * PROD_W'(req.b);

  always_comb begin
    case (req.op)
      ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
      // The top bit is the borrow: set when a is below b.
      ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
      ALU_MUL: res = ALU_W'(prod[PROD_W-1:LEVEL_W-1]);
      default: res = '0;
    endcase
  end

endmodule

// ----- tb/tb_led_breathing_palette_dimmer.sv -----
`timescale 1ns / 1ps

module tb_led_breathing_palette_dimmer;
  import lbpd_pkg::*;

  // One output pixel as the checker sees it.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             clear;
    logic             last;
  } pixel_t;

  // Keeps a shadow copy of the registers and of the breathing level, works out the
  // pixel that every accepted slot must produce, and compares the pixels in order.
  class pixel_checker;
    logic [COLOR_W-1:0]  palette [PALETTE_REGS];
    logic [COLCNT_W-1:0] color_count;
    logic [PIXCNT_W-1:0] pixel_count;
    logic [STEP_W-1:0]   step;
    logic [LEVEL_W-1:0]  level;
    bit                  rising;
    pixel_t              expected_pixels [$];
    int                  errors;

    function new();
      foreach (palette[i]) palette[i] = '0;
      color_count = COLCNT_W'(1);
      pixel_count = PIXCNT_W'(1024);
      step        = STEP_RESET;
      level       = FULL_SCALE;
      rising      = 1'b0;
      errors      = 0;
    endfunction

    task report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    function int eff_pixels();
      int n;
      n = int'(pixel_count);
      if (n < 1) n = 1;
      if (n > MAX_PIXELS_DEF) n = MAX_PIXELS_DEF;
      return n;
    endfunction

    function int eff_colors();
      int n;
      n = int'(color_count);
      if (n < 1) n = 1;
      if (n > MAX_COLORS_DEF) n = MAX_COLORS_DEF;
      return n;
    endfunction

    function void write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
      case (r)
        REG_COLOR_COUNT: color_count = d[COLCNT_W-1:0];
        REG_PIXEL_COUNT: pixel_count = d[PIXCNT_W-1:0];
        REG_STEP:        step        = d[STEP_W-1:0];
        default:         palette[int'(r)] = d[COLOR_W-1:0];
      endcase
    endfunction

    // Channel times level in 16-bit fraction, truncated.
    function logic [CH_W-1:0] dim(logic [CH_W-1:0] c);
      logic [CH_W+LEVEL_W-1:0] prod;
      prod = (CH_W+LEVEL_W)'(c) * (CH_W+LEVEL_W)'(level);
      return prod[CH_W+15:16];
    endfunction

    // One step of the triangle between the floor and full scale.
    function void step_level();
      int unsigned s;
      int unsigned v;
      s = 32'(step);
      if (s > 32'(FULL_SCALE)) s = 32'(FULL_SCALE);
      if (rising) begin
        v = 32'(level) + s;
        if (v >= 32'(FULL_SCALE)) begin
          v = 32'(FULL_SCALE);
          rising = 1'b0;
        end
        level = LEVEL_W'(v);
      end else if (32'(level) <= 32'(FLOOR_LEVEL) + s) begin
        level = FLOOR_LEVEL;
        rising = 1'b1;
      end else begin
        level = LEVEL_W'(32'(level) - s);
      end
    endfunction

    function void accept_slot(action_t act, logic [IDX_W-1:0] pix);
      pixel_t             e;
      logic [COLOR_W-1:0] c;
      int                 slot;
      e = '0;
      e.idx  = pix;
      e.last = (int'(pix) == eff_pixels() - 1);
      case (act)
        ACT_BEGIN: begin
          level = '0;
          rising = 1'b1;
        end
        ACT_LOOP: begin
          slot = int'(pix) % eff_colors();
          c = (slot < PALETTE_REGS) ? palette[slot] : '0;
          e.red   = dim(c[23:16]);
          e.green = dim(c[15:8]);
          e.blue  = dim(c[7:0]);
          if (e.last) step_level();
        end
        ACT_END: begin
          level = '0;
          rising = 1'b0;
        end
        default: begin
          e.idx   = '0;
          e.clear = 1'b1;
          e.last  = 1'b0;
        end
      endcase
      expected_pixels.push_back(e);
    endfunction

    task check_field(string name, int got, int exp);
      if (got != exp) report($sformatf("%s got 0x%0h expected 0x%0h", name, got, exp));
    endtask

    task check_pixel(pixel_t got);
      pixel_t e;
      if (expected_pixels.size() == 0) begin
        report($sformatf("pixel for index %0d arrived with none outstanding", got.idx));
        return;
      end
      e = expected_pixels.pop_front();
      check_field("out_index", int'(got.idx), int'(e.idx));
      check_field("red", int'(got.red), int'(e.red));
      check_field("green", int'(got.green), int'(e.green));
      check_field("blue", int'(got.blue), int'(e.blue));
      check_field("clear_all", int'(got.clear), int'(e.clear));
      check_field("frame_last", int'(got.last), int'(e.last));
    endtask
  endclass

  logic clk;
  logic rst_n;

  lbpd_in_if  in_bus ();
  lbpd_out_if out_bus ();
  lbpd_cfg_if cfg_bus ();

  led_breathing_palette_dimmer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  pixel_checker sb;
  int           items_sent;
  // When set, the matching side never idles.
  bit           in_quiet;
  bit           out_quiet;
  // Asks the receiver for one long hold-off so that the block backs up.
  bit           choke_req;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  // One register write. Valid drops after the transfer and the task returns only after the
  // next clock edge, so back-to-back writes never assign valid twice in the same step.
  task automatic cfg_write(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= r;
    cfg_bus.data  <= d;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    sb.write_reg(r, d);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one pixel slot after an optional gap. Valid stays high on return so that
  // the next slot can follow without a bubble.
  task automatic send_slot(action_t act, logic [IDX_W-1:0] pix);
    int gap;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.action      <= act;
    in_bus.pixel_index <= pix;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.accept_slot(act, pix);
    items_sent++;
  endtask

  // Wait until every outstanding pixel has arrived, then idle before the registers are
  // written again.
  task automatic drain();
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Result side: checks every transfer and drives ready with random hold-offs. The
  // long hold-off is counted here, independently of the sender.
  initial begin : result_sink
    int     hold;
    pixel_t got;
    hold = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        got.idx   = out_bus.out_index;
        got.red   = out_bus.red;
        got.green = out_bus.green;
        got.blue  = out_bus.blue;
        got.clear = out_bus.clear_all;
        got.last  = out_bus.frame_last;
        sb.check_pixel(got);
      end
      if (hold > 0) begin
        hold--;
        out_bus.ready <= 1'b0;
      end else if (choke_req) begin
        choke_req = 1'b0;
        hold = 399;
        out_bus.ready <= 1'b0;
      end else begin
        hold = pick_gap(out_quiet);
        if (hold > 0) begin
          hold--;
          out_bus.ready <= 1'b0;
        end else begin
          out_bus.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    int                    phase;
    int                    goal;
    int                    r;
    int                    n_pix;
    int                    frames;
    logic [CFG_DATA_W-1:0] val;
    logic [CFG_DATA_W-1:0] mask;

    sb         = new();
    items_sent = 0;
    in_quiet   = 1'b0;
    out_quiet  = 1'b0;
    choke_req  = 1'b0;

    // Every block input has a known value from time zero.
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.action      <= ACT_BEGIN;
    in_bus.pixel_index <= '0;
    out_bus.ready      <= 1'b0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= REG_PAL0;
    cfg_bus.data       <= '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: black palette, one color, full-length strip, and the
    // level at full scale and falling. The last index of the strip steps it down.
    send_slot(ACT_OFF, IDX_W'(1023));
    send_slot(ACT_LOOP, IDX_W'(1023));
    send_slot(ACT_BEGIN, IDX_W'(0));
    in_bus.valid <= 1'b0;
    drain();

    // A four-pixel strip with a full-scale step, so the level jumps between the
    // floor and the top on every frame and each turn is hit right away.
    cfg_write(REG_PAL0, 24'hFFFFFF);
    cfg_write(REG_PAL1, 24'h000000);
    cfg_write(REG_PAL2, 24'h80FF01);
    cfg_write(REG_PAL3, 24'h123456);
    cfg_write(REG_PAL4, 24'hFEDCBA);
    cfg_write(REG_COLOR_COUNT, 24'd5);
    cfg_write(REG_PIXEL_COUNT, 24'd4);
    cfg_write(REG_STEP, 24'd65536);

    send_slot(ACT_BEGIN, IDX_W'(3));
    // Level is zero: black pixels, then a rise straight to full scale.
    for (int p = 0; p < 4; p++) send_slot(ACT_LOOP, IDX_W'(p));
    // Full-scale colors, then a fall that clamps at the floor.
    for (int p = 0; p < 4; p++) send_slot(ACT_LOOP, IDX_W'(p));
    // Pixels past the end of the strip are emitted but leave the level alone.
    send_slot(ACT_LOOP, IDX_W'(4));
    send_slot(ACT_LOOP, IDX_W'(1023));
    // A loop right after end starts from zero and falling, so it clamps to the floor.
    send_slot(ACT_END, IDX_W'(0));
    send_slot(ACT_LOOP, IDX_W'(3));
    // Repeated begin and end each reset the level again.
    send_slot(ACT_BEGIN, IDX_W'(1));
    send_slot(ACT_BEGIN, IDX_W'(2));
    send_slot(ACT_END, IDX_W'(3));
    send_slot(ACT_END, IDX_W'(3));
    send_slot(ACT_OFF, IDX_W'(0));
    send_slot(ACT_OFF, IDX_W'(1023));
    in_bus.valid <= 1'b0;
    drain();

    // Random phases. Each one reprograms every register while the block is idle,
    // including out-of-range counts and steps, then mostly plays whole frames so the
    // level keeps walking its triangle, with some random slots mixed in.
    phase = 0;
    while (items_sent < 1290) begin
      in_quiet  = (phase % 5 == 3);
      out_quiet = (phase % 5 == 3);

      for (int i = 0; i < PALETTE_REGS; i++) begin
        r = $urandom_range(0, 9);
        if (r == 0) val = '0;
        else if (r == 1) val = 24'hFFFFFF;
        else val = CFG_DATA_W'($urandom());
        cfg_write(cfg_reg_t'(i), val);
      end

      // Color count covers all eight field values, zero and above five included.
      val = CFG_DATA_W'($urandom_range(0, 7));
      mask = CFG_DATA_W'(7);
      if ($urandom_range(0, 2) == 0) val |= ~mask & CFG_DATA_W'($urandom());
      cfg_write(REG_COLOR_COUNT, val);

      // Short strips dominate so frames complete quickly.
      r = $urandom_range(0, 99);
      if (r < 60) val = CFG_DATA_W'($urandom_range(1, 12));
      else if (r < 68) val = CFG_DATA_W'(1);
      else if (r < 76) val = '0;
      else if (r < 84) val = CFG_DATA_W'(1024);
      else if (r < 92) val = CFG_DATA_W'($urandom_range(1025, 2047));
      else val = CFG_DATA_W'($urandom_range(13, 1023));
      mask = CFG_DATA_W'(2047);
      if ($urandom_range(0, 2) == 0) val |= ~mask & CFG_DATA_W'($urandom());
      cfg_write(REG_PIXEL_COUNT, val);

      r = $urandom_range(0, 99);
      if (r < 25) val = CFG_DATA_W'($urandom_range(1, 1000));
      else if (r < 55) val = CFG_DATA_W'($urandom_range(1000, 20000));
      else if (r < 65) val = CFG_DATA_W'(65536);
      else if (r < 72) val = '0;
      else if (r < 80) val = CFG_DATA_W'($urandom_range(65537, 131071));
      else if (r < 88) val = CFG_DATA_W'(1);
      else val = CFG_DATA_W'($urandom_range(20000, 65535));
      mask = CFG_DATA_W'(131071);
      if ($urandom_range(0, 2) == 0) val |= ~mask & CFG_DATA_W'($urandom());
      cfg_write(REG_STEP, val);

      // In one phase the receiver stops for a long while and the sender pushes on
      // without gaps until the block refuses input.
      if (phase == 2) begin
        in_quiet  = 1'b1;
        choke_req = 1'b1;
      end

      goal = items_sent + $urandom_range(90, 130);
      while (items_sent < goal) begin
        n_pix = sb.eff_pixels();
        if ($urandom_range(0, 99) < 75) begin
          r = $urandom_range(0, 99);
          if (r < 55) send_slot(ACT_BEGIN, IDX_W'($urandom_range(0, 1023)));
          else if (r < 70) send_slot(ACT_END, IDX_W'($urandom_range(0, 1023)));
          frames = $urandom_range(1, 4);
          repeat (frames) begin
            if (n_pix <= 48) begin
              for (int p = 0; p < n_pix; p++) send_slot(ACT_LOOP, IDX_W'(p));
            end else begin
              // Long strips get a sparse frame that still ends on the last pixel.
              repeat ($urandom_range(3, 8))
                send_slot(ACT_LOOP, IDX_W'($urandom_range(0, n_pix - 2)));
              send_slot(ACT_LOOP, IDX_W'(n_pix - 1));
            end
          end
          r = $urandom_range(0, 99);
          if (r < 30) send_slot(ACT_END, IDX_W'($urandom_range(0, 1023)));
          else if (r < 40) send_slot(ACT_OFF, IDX_W'($urandom_range(0, 1023)));
        end else begin
          repeat ($urandom_range(1, 6))
            send_slot(action_t'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 1023)));
        end
      end
      in_bus.valid <= 1'b0;
      drain();
      phase++;
    end

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin : watchdog
    #6_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/lbpd_pkg.sv
rtl/lbpd_ifs.sv
rtl/lbpd_alu.sv
rtl/led_breathing_palette_dimmer.sv
tb/tb_led_breathing_palette_dimmer.sv
